@@ sv/mdfs_pkg.sv @@
// ----------------------------------------------------------------------------
// mdfs_pkg: shared types and codes of the maze path finder
// Word layouts of both channels, operation and direction codes, register map.
// ----------------------------------------------------------------------------
package mdfs_pkg;

  localparam int MAX_ROWS_DEF = 16;
  localparam int MAX_COLS_DEF = 16;

  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;
  localparam int REG_SEL_BIT  = 2;
  localparam int DIM_W        = 5;
  localparam int DIR_W        = 3;
  localparam int LEN_W        = 9;
  localparam int IDX_W        = 8;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_SOLVE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [DIR_W-1:0] DIR_GOAL  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_EAST  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_SOUTH = 3'd2;
  localparam logic [DIR_W-1:0] DIR_WEST  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_NORTH = 3'd4;
  localparam logic [DIR_W-1:0] DIR_DONE  = 3'd5;

  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  // cell memory word: wall bit above visited bit
  localparam int         CELL_WALL      = 1;
  localparam int         CELL_SEEN      = 0;
  localparam logic [1:0] CELL_OPEN_SEEN = 2'b01;

  typedef struct packed {
    logic [1:0]       op;
    logic [DIM_W-1:0] cell_row;
    logic [DIM_W-1:0] cell_col;
    logic             cell_wall;
    logic [IDX_W-1:0] step_index;
  } in_word_t;

  typedef struct packed {
    logic             found;
    logic [LEN_W-1:0] path_length;
    logic [DIM_W-1:0] step_row;
    logic [DIM_W-1:0] step_col;
    logic [DIR_W-1:0] step_dir;
  } out_word_t;

endpackage

@@ sv/grid_maze_dfs_path_finder_core.sv @@
// ----------------------------------------------------------------------------
// grid_maze_dfs_path_finder_core: maze depth-first search with explicit stack
// Loads wall cells, solves from (1,1) to (num_rows,num_cols), reads the path.
//
//   channel | ports                                      | word
//   in      | in_valid, in_stall, in_word                | in_word_t
//   out     | out_valid, out_stall, out_word             | out_word_t
//   config  | psel, penable, pwrite, paddr, pwdata, ... | num_rows, num_cols
//
// Load: no result. Read: one stack memory read, then the output register.
// Solve: a pass of visited clearing through the cell memory, then a search
// that goes through STEP and PROBE per probed neighbor, STEP alone per
// out-of-grid direction, and STEP and POP per pop.
// Synchronous reset; no item is taken while a result waits for the output.
// ----------------------------------------------------------------------------
module grid_maze_dfs_path_finder_core import mdfs_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = $clog2(CELLS + 1);
  localparam int EW    = RW + CW + DIR_W;
  localparam int RXW   = (RW > DIM_W) ? RW : DIM_W;
  localparam int CXW   = (CW > DIM_W) ? CW : DIM_W;
  localparam int LW    = (SW > IDX_W) ? SW : IDX_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLEAR  = 3'd1;
  localparam logic [2:0] S_STEP   = 3'd2;
  localparam logic [2:0] S_PROBE  = 3'd3;
  localparam logic [2:0] S_POP    = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [SW-1:0]    sp_r, sp_nxt;
  logic             solved_r, solved_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [DIR_W-1:0] dir_r, dir_nxt;
  logic [SW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic             rd_hit_r, rd_hit_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;
  logic [DIM_W-1:0] num_rows_r, num_cols_r;

  logic [RXW-1:0]   rows_x;
  logic [CXW-1:0]   cols_x;
  logic [RW-1:0]    rows_eff;
  logic [CW-1:0]    cols_eff;

  logic             nb_ok;
  logic [RW-1:0]    nb_row;
  logic [CW-1:0]    nb_col;
  logic [AW-1:0]    nb_addr;
  logic [AW-1:0]    ld_addr;
  logic             ld_in_range;
  logic             at_goal;
  logic             out_free;

  logic             cell_we, cell_re;
  logic [AW-1:0]    cell_waddr, cell_raddr;
  logic [1:0]       cell_wdata, cell_rdata;
  logic             stk_we, stk_re;
  logic [AW-1:0]    stk_waddr, stk_raddr;
  logic [EW-1:0]    stk_wdata, stk_rdata;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[REG_SEL_BIT] == REG_NUM_COLS) ? CFG_DATA_W'(num_cols_r)
                                                      : CFG_DATA_W'(num_rows_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= DIM_RESET;
      num_cols_r <= DIM_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[REG_SEL_BIT])
        REG_NUM_ROWS: num_rows_r <= pwdata[DIM_W-1:0];
        REG_NUM_COLS: num_cols_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp dimensions to 1..MAX
  assign rows_x = RXW'(num_rows_r);
  assign cols_x = CXW'(num_cols_r);
  assign rows_eff = (num_rows_r == '0) ? RW'(1) :
                    (rows_x > RXW'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(rows_x);
  assign cols_eff = (num_cols_r == '0) ? CW'(1) :
                    (cols_x > CXW'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(cols_x);

  assign at_goal = (row_r == rows_eff) && (col_r == cols_eff);

  always_comb begin
    nb_ok  = 1'b0;
    nb_row = row_r;
    nb_col = col_r;
    unique case (dir_r)
      DIR_EAST: begin
        nb_ok  = col_r < cols_eff;
        nb_col = col_r + CW'(1);
      end
      DIR_SOUTH: begin
        nb_ok  = row_r < rows_eff;
        nb_row = row_r + RW'(1);
      end
      DIR_WEST: begin
        nb_ok  = col_r > CW'(1);
        nb_col = col_r - CW'(1);
      end
      DIR_NORTH: begin
        nb_ok  = row_r > RW'(1);
        nb_row = row_r - RW'(1);
      end
      default: nb_ok = 1'b0;
    endcase
  end

  assign nb_addr = AW'(nb_row - RW'(1)) * AW'(MAX_COLS) + AW'(nb_col - CW'(1));

  assign ld_in_range = (in_word.cell_row != '0) && (in_word.cell_col != '0) &&
                       (RXW'(in_word.cell_row) <= RXW'(MAX_ROWS)) &&
                       (CXW'(in_word.cell_col) <= CXW'(MAX_COLS));
  assign ld_addr = AW'(in_word.cell_row - DIM_W'(1)) * AW'(MAX_COLS) +
                   AW'(in_word.cell_col - DIM_W'(1));

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    sp_nxt        = sp_r;
    solved_nxt    = solved_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    dir_nxt       = dir_r;
    clr_cnt_nxt   = clr_cnt_r;
    rd_hit_nxt    = rd_hit_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;

    cell_we    = 1'b0;
    cell_waddr = nb_addr;
    cell_wdata = CELL_OPEN_SEEN;
    cell_re    = 1'b0;
    cell_raddr = nb_addr;
    stk_we     = 1'b0;
    stk_waddr  = sp_r[AW-1:0];
    stk_wdata  = {row_r, col_r, dir_r};
    stk_re     = 1'b0;
    stk_raddr  = AW'(sp_r - SW'(1));

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_word.op)
            OP_LOAD: begin
              cell_we    = ld_in_range;
              cell_waddr = ld_addr;
              cell_wdata = {in_word.cell_wall, 1'b0};
            end
            OP_SOLVE: begin
              state_nxt   = S_CLEAR;
              clr_cnt_nxt = '0;
              sp_nxt      = '0;
              solved_nxt  = 1'b0;
              row_nxt     = RW'(1);
              col_nxt     = CW'(1);
              dir_nxt     = DIR_EAST;
              rd_hit_nxt  = 1'b0;
            end
            OP_READ: begin
              stk_re     = 1'b1;
              stk_raddr  = AW'(in_word.step_index);
              rd_hit_nxt = solved_r && (LW'(in_word.step_index) < LW'(sp_r));
              state_nxt  = S_RESULT;
            end
            default: ;
          endcase
        end
      end
      S_CLEAR: begin
        cell_re    = (clr_cnt_r != SW'(CELLS));
        cell_raddr = clr_cnt_r[AW-1:0];
        cell_we    = (clr_cnt_r != '0);
        cell_waddr = AW'(clr_cnt_r - SW'(1));
        cell_wdata = {cell_rdata[CELL_WALL], clr_cnt_r == SW'(1)};
        if (clr_cnt_r == SW'(CELLS)) begin
          state_nxt = S_STEP;
        end else begin
          clr_cnt_nxt = clr_cnt_r + SW'(1);
        end
      end
      S_STEP: begin
        if (at_goal) begin
          stk_we     = 1'b1;
          stk_wdata  = {row_r, col_r, DIR_GOAL};
          sp_nxt     = sp_r + SW'(1);
          solved_nxt = 1'b1;
          state_nxt  = S_RESULT;
        end else if (dir_r == DIR_DONE) begin
          if (sp_r == '0) begin
            state_nxt = S_RESULT;
          end else begin
            stk_re    = 1'b1;
            sp_nxt    = sp_r - SW'(1);
            state_nxt = S_POP;
          end
        end else if (nb_ok) begin
          cell_re   = 1'b1;
          state_nxt = S_PROBE;
        end else begin
          dir_nxt = dir_r + DIR_W'(1);
        end
      end
      S_PROBE: begin
        if (!cell_rdata[CELL_WALL] && !cell_rdata[CELL_SEEN]) begin
          stk_we  = 1'b1;
          sp_nxt  = sp_r + SW'(1);
          cell_we = 1'b1;
          row_nxt = nb_row;
          col_nxt = nb_col;
          dir_nxt = DIR_EAST;
        end else begin
          dir_nxt = dir_r + DIR_W'(1);
        end
        state_nxt = S_STEP;
      end
      S_POP: begin
        row_nxt   = stk_rdata[EW-1 -: RW];
        col_nxt   = stk_rdata[DIR_W +: CW];
        dir_nxt   = stk_rdata[DIR_W-1:0] + DIR_W'(1);
        state_nxt = S_STEP;
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.found       = solved_r;
          out_word_nxt.path_length = solved_r ? LEN_W'(sp_r) : '0;
          out_word_nxt.step_row    = rd_hit_r ? DIM_W'(stk_rdata[EW-1 -: RW]) : '0;
          out_word_nxt.step_col    = rd_hit_r ? DIM_W'(stk_rdata[DIR_W +: CW]) : '0;
          out_word_nxt.step_dir    = rd_hit_r ? stk_rdata[DIR_W-1:0] : '0;
          state_nxt                = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      solved_r    <= 1'b0;
      rd_hit_r    <= 1'b0;
      out_valid_r <= 1'b0;
      clr_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      solved_r    <= solved_nxt;
      rd_hit_r    <= rd_hit_nxt;
      out_valid_r <= out_valid_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    dir_r      <= dir_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  mdfs_ram #(
    .WIDTH (2),
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk     (clk),
    .wr_en   (cell_we),
    .wr_addr (cell_waddr),
    .wr_data (cell_wdata),
    .rd_en   (cell_re),
    .rd_addr (cell_raddr),
    .rd_data (cell_rdata)
  );

  mdfs_ram #(
    .WIDTH (EW),
    .DEPTH (CELLS)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_en   (stk_re),
    .rd_addr (stk_raddr),
    .rd_data (stk_rdata)
  );

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SW'(CELLS))
    else $error("stack depth beyond grid size");

  a_solved_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    solved_r |-> (sp_r != '0))
    else $error("solved with empty stack");

  a_step_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP) |-> ((dir_r != DIR_GOAL) && (dir_r <= DIR_DONE)))
    else $error("search direction out of range");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_RESULT) && out_valid_r && out_stall) |=> (state_r == S_RESULT))
    else $error("result dropped while output stalled");

endmodule

@@ sv/mdfs_ram.sv @@
// ----------------------------------------------------------------------------
// mdfs_ram: generic simple dual-port RAM
// One write port, one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module mdfs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the maze depth-first search path finder
// Loads wall grids, sets the grid size over the register port, solves and
// reads path entries back. A predictor in this file runs the same search on
// its own copy of the grid; every result word is checked field by field
// against it, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import mdfs_pkg::*;

  localparam int          IN_W           = $bits(in_word_t);
  localparam logic [1:0]  OP_SPARE       = 2'd3;
  localparam int          SETTLE_CYCLES  = 16;
  localparam int          DRAIN_CYCLES   = 50;
  localparam int          HOLD_CYCLES    = 200;
  localparam int          PHASE_ITEMS    = 265;
  localparam longint      TIMEOUT_CYCLES = 4_000_000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_word = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // predictor state
  bit                    cell_blocked [0:MAX_ROWS_DEF-1][0:MAX_COLS_DEF-1];
  bit                    cell_seen    [0:MAX_ROWS_DEF-1][0:MAX_COLS_DEF-1];
  logic [DIM_W-1:0]      trail_row [0:MAX_ROWS_DEF*MAX_COLS_DEF];
  logic [DIM_W-1:0]      trail_col [0:MAX_ROWS_DEF*MAX_COLS_DEF];
  logic [DIR_W-1:0]      trail_dir [0:MAX_ROWS_DEF*MAX_COLS_DEF];
  int                    trail_len = 0;
  bit                    path_ok = 1'b0;
  logic [DIM_W-1:0]      grid_rows = DIM_RESET;
  logic [DIM_W-1:0]      grid_cols = DIM_RESET;

  out_word_t             answers_due [$];
  int                    mismatches = 0;
  int                    work_items = 0;
  int unsigned           gap_pct = 0;
  int unsigned           stall_pct = 0;
  int                    hold_left = 0;

  grid_maze_dfs_path_finder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int fit_dim(int v, int lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic void push_trail(int r, int c, int d);
    if (trail_len <= MAX_ROWS_DEF * MAX_COLS_DEF) begin
      trail_row[trail_len] = DIM_W'(r);
      trail_col[trail_len] = DIM_W'(c);
      trail_dir[trail_len] = DIR_W'(d);
      trail_len++;
    end
  endfunction

  function automatic void search_maze();
    int  rows, cols, r, c, nr, nc, nxt, d;
    bit  moved, ok;
    rows = fit_dim(grid_rows, MAX_ROWS_DEF);
    cols = fit_dim(grid_cols, MAX_COLS_DEF);
    foreach (cell_seen[i, j]) cell_seen[i][j] = 1'b0;
    trail_len = 0;
    path_ok = 1'b0;
    r = 1;
    c = 1;
    nxt = DIR_EAST;
    cell_seen[0][0] = 1'b1;
    while (1) begin
      if (r == rows && c == cols) begin
        push_trail(r, c, DIR_GOAL);
        path_ok = 1'b1;
        return;
      end
      moved = 1'b0;
      for (d = nxt; d <= DIR_NORTH && !moved; d++) begin
        nr = r;
        nc = c;
        if (d == DIR_EAST) begin
          ok = c + 1 <= cols;
          nc = c + 1;
        end else if (d == DIR_SOUTH) begin
          ok = r + 1 <= rows;
          nr = r + 1;
        end else if (d == DIR_WEST) begin
          ok = c >= 2;
          nc = c - 1;
        end else begin
          ok = r >= 2;
          nr = r - 1;
        end
        if (ok && !cell_blocked[nr-1][nc-1] && !cell_seen[nr-1][nc-1]) begin
          push_trail(r, c, d);
          cell_seen[nr-1][nc-1] = 1'b1;
          r = nr;
          c = nc;
          nxt = DIR_EAST;
          moved = 1'b1;
        end
      end
      if (moved) continue;
      if (trail_len == 0) return;
      trail_len--;
      r = trail_row[trail_len];
      c = trail_col[trail_len];
      nxt = trail_dir[trail_len] + 1;
    end
  endfunction

  // update grid state for one accepted word; returns 0 for ignored words
  function automatic bit advance_maze(in_word_t w);
    out_word_t ans;
    int        len;
    if (w.op == OP_LOAD) begin
      if (w.cell_row < 1 || w.cell_row > MAX_ROWS_DEF ||
          w.cell_col < 1 || w.cell_col > MAX_COLS_DEF) return 1'b0;
      cell_blocked[w.cell_row-1][w.cell_col-1] = w.cell_wall;
      return 1'b1;
    end
    if (w.op == OP_SPARE) return 1'b0;
    if (w.op == OP_SOLVE) search_maze();
    len = path_ok ? trail_len : 0;
    ans = '0;
    ans.found = path_ok;
    ans.path_length = LEN_W'(len);
    if (w.op == OP_READ && path_ok && w.step_index < len) begin
      ans.step_row = trail_row[w.step_index];
      ans.step_col = trail_col[w.step_index];
      ans.step_dir = trail_dir[w.step_index];
    end
    answers_due.push_back(ans);
    return 1'b1;
  endfunction

  function automatic in_word_t fresh_word(logic [1:0] op);
    in_word_t w;
    w = IN_W'($urandom);
    w.op = op;
    return w;
  endfunction

  function automatic int pick_index();
    int len;
    len = path_ok ? trail_len : 0;
    case ($urandom_range(5))
      0: return $urandom_range(255);
      1: return len;
      default: return (len > 0) ? $urandom_range(len - 1) : $urandom_range(255);
    endcase
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(9))
      0: return 1;
      1: return 16;
      2: return $urandom_range(1) ? 0 : $urandom_range(17, 31);
      default: return $urandom_range(2, 6);
    endcase
  endfunction

  function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (answers_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, got %p", $time, out_word);
      end else begin
        want = answers_due.pop_front();
        cmp_field("found", want.found, out_word.found);
        cmp_field("path_length", want.path_length, out_word.path_length);
        cmp_field("step_row", want.step_row, out_word.step_row);
        cmp_field("step_col", want.step_col, out_word.step_col);
        cmp_field("step_dir", want.step_dir, out_word.step_dir);
      end
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (advance_maze(w)) work_items++;
  endtask

  task automatic load_cell(input int r, input int c, input bit wall);
    in_word_t w;
    w = fresh_word(OP_LOAD);
    w.cell_row = DIM_W'(r);
    w.cell_col = DIM_W'(c);
    w.cell_wall = wall;
    send_word(w);
  endtask

  task automatic solve_maze();
    send_word(fresh_word(OP_SOLVE));
  endtask

  task automatic read_step(input int idx);
    in_word_t w;
    w = fresh_word(OP_READ);
    w.step_index = IDX_W'(idx);
    send_word(w);
  endtask

  task automatic send_noise();
    in_word_t w;
    w = fresh_word(OP_LOAD);
    if ($urandom_range(1)) begin
      w.op = OP_SPARE;
    end else if ($urandom_range(1)) begin
      w.cell_row = $urandom_range(1) ? '0 : DIM_W'($urandom_range(17, 31));
    end else begin
      w.cell_col = $urandom_range(1) ? '0 : DIM_W'($urandom_range(17, 31));
    end
    send_word(w);
  endtask

  // drop valid and wait until the block has drained
  task automatic settle();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic reg_idx, input logic [DIM_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(reg_idx) << REG_SEL_BIT;
    pwdata  <= {(CFG_DATA_W-DIM_W)'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_NUM_ROWS) grid_rows = val;
    else grid_cols = val;
    @(posedge clk);
  endtask

  task automatic set_dims(input int rows, input int cols);
    settle();
    write_reg(REG_NUM_ROWS, DIM_W'(rows));
    write_reg(REG_NUM_COLS, DIM_W'(cols));
  endtask

  task automatic test_empty_reads();
    read_step(0);
    read_step(255);
    send_word(fresh_word(OP_SPARE));
    load_cell(0, 5, 1'b1);
    load_cell(5, 0, 1'b1);
    load_cell(17, 3, 1'b1);
    load_cell(3, 17, 1'b1);
    load_cell(31, 31, 1'b1);
    read_step(1);
  endtask

  task automatic test_single_cell();
    set_dims(1, 1);
    load_cell(1, 1, 1'b1);
    solve_maze();
    read_step(0);
    read_step(1);
    set_dims(0, 0);
    solve_maze();
    read_step(0);
  endtask

  task automatic test_blocked_goal();
    set_dims(2, 2);
    load_cell(1, 1, 1'b0);
    load_cell(1, 2, 1'b1);
    load_cell(2, 1, 1'b1);
    load_cell(2, 2, 1'b0);
    solve_maze();
    read_step(0);
    load_cell(1, 2, 1'b0);
    solve_maze();
    for (int i = 0; i < 4; i++) read_step(i);
  endtask

  task automatic test_full_grid();
    int gap_col;
    set_dims(16, 16);
    // comb of walls on even rows but the last, one gap alternating between the ends
    for (int r = 1; r <= MAX_ROWS_DEF; r++) begin
      gap_col = (r % 4 == 2) ? MAX_COLS_DEF : 1;
      for (int c = 1; c <= MAX_COLS_DEF; c++) begin
        load_cell(r, c, (r % 2 == 0) && r != MAX_ROWS_DEF && c != gap_col);
      end
    end
    solve_maze();
    for (int i = 0; i <= trail_len; i++) read_step(i);
    read_step(255);
    set_dims(31, 17);
    solve_maze();
    read_step(trail_len - 1);
    set_dims(16, 16);
    load_cell(16, 16, 1'b1);
    solve_maze();
    read_step(0);
    load_cell(16, 16, 1'b0);
  endtask

  task automatic test_backpressure();
    gap_pct = 0;
    stall_pct = 0;
    set_dims(16, 16);
    solve_maze();
    settle();
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 24; i++) read_step(pick_index());
    settle();
  endtask

  task automatic run_random_maze();
    int rows, cols, wall_pct, passes;
    rows = pick_dim();
    cols = pick_dim();
    set_dims(rows, cols);
    rows = fit_dim(rows, MAX_ROWS_DEF);
    cols = fit_dim(cols, MAX_COLS_DEF);
    wall_pct = $urandom_range(0, 45);
    for (int r = 1; r <= rows; r++) begin
      for (int c = 1; c <= cols; c++) begin
        if ($urandom_range(99) < 8) send_noise();
        load_cell(r, c, $urandom_range(99) < wall_pct);
      end
    end
    passes = ($urandom_range(3) == 0) ? 2 : 1;
    for (int p = 0; p < passes; p++) begin
      if (p > 0) begin
        repeat ($urandom_range(1, 4)) begin
          load_cell($urandom_range(1, rows), $urandom_range(1, cols),
                    $urandom_range(1));
        end
      end
      solve_maze();
      repeat ($urandom_range(2, 8)) read_step(pick_index());
    end
  endtask

  task automatic test_random_mazes();
    int unsigned gap_by_phase [4]   = '{0, 53, 0, 13};
    int unsigned stall_by_phase [4] = '{0, 0, 53, 13};
    int          phase_end;
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = gap_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      phase_end = work_items + PHASE_ITEMS;
      while (work_items < phase_end) run_random_maze();
    end
    gap_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_reads();
    test_single_cell();
    test_blocked_goal();
    test_full_grid();
    test_backpressure();
    test_random_mazes();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 8);
    $display("FAILURE");
    $finish;
  end

endmodule
